// File: rtl/dmp_pkg.sv
package dmp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [7:0] PTR_MARK  = 8'hc0;
    localparam logic [7:0] MAX_LABEL = 8'd63;
    localparam logic [3:0] HDR_LAST  = 4'd11;
    localparam logic [7:0] DOT_CHAR  = 8'h2e;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HDR, PH_NLEN, PH_LABEL, PH_PTR2, PH_FIXED, PH_RDATA, PH_DONE, PH_ERR
    } t_phase;

    typedef enum logic [2:0] {
        EV_HDR    = 3'd0,
        EV_COUNT  = 3'd1,
        EV_CHAR   = 3'd2,
        EV_NAME   = 3'd3,
        EV_RECORD = 3'd4,
        EV_MSG    = 3'd5,
        EV_BAD    = 3'd6
    } t_event;

    typedef struct packed {
        t_event      ev;
        logic [1:0]  sec;
        logic [15:0] idx;
        logic [7:0]  ch;
        logic        isp;
        logic [13:0] off;
        logic [15:0] rtype;
        logic [15:0] rclass;
        logic [31:0] ttl;
        logic [15:0] id;
        logic [15:0] flags;
    } t_res;

    typedef struct packed {
        logic             is_hdr;
        logic             add_done;
        logic [3:0][15:0] cnt;
        t_res             res;
    } t_cmd;

    // {found, section}: first section at or after s with a nonzero count
    function automatic logic [2:0] pick_section(input logic [2:0] s,
                                                input logic [2:0][15:0] c);
        logic [2:0] r;
        r = 3'b000;
        for (int i = 1; i <= 3; i++) begin
            if (!r[2] && (3'(i) >= s) && (c[i-1] != 16'd0)) begin
                r = {1'b1, 2'(i)};
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/dmp_in_if.sv
interface dmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       msg_start;

    modport source (output valid, msg_byte, msg_start, input ready);
    modport sink   (input valid, msg_byte, msg_start, output ready);
endinterface

// File: rtl/dmp_out_if.sv
interface dmp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [1:0]  section;
    logic [15:0] record_index;
    logic [7:0]  name_char;
    logic        is_pointer;
    logic [13:0] pointer_offset;
    logic [15:0] rec_type;
    logic [15:0] rec_class;
    logic [31:0] rec_ttl;
    logic [15:0] msg_id;
    logic [15:0] hdr_flags;
    logic        last;

    modport source (output valid, event_res, section, record_index, name_char, is_pointer,
                    pointer_offset, rec_type, rec_class, rec_ttl, msg_id, hdr_flags, last,
                    input ready);
    modport sink   (input valid, event_res, section, record_index, name_char, is_pointer,
                    pointer_offset, rec_type, rec_class, rec_ttl, msg_id, hdr_flags, last,
                    output ready);
endinterface

// File: rtl/dns_message_parser_unit.sv
// Accepts one message byte per cycle while the command queue has room.
// An accepted byte's first result passes through the command queue and then the output register.
// Results leave at one per cycle while the output is ready; a header end expands into up to six, and the
// four-entry command queue absorbs such bursts against the byte stream.
// Reset (synchronous, active low) empties the queue and returns the parser to idle.
module dns_message_parser_unit
    import dmp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dmp_in_if.sink    i_msg,
    dmp_out_if.source o_res
);

    logic q_full, q_push, q_pop, q_valid;
    t_cmd f_cmd, q_cmd;
    t_res b_res;

    dmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_msg.valid),
        .i_byte  (i_msg.msg_byte),
        .i_start (i_msg.msg_start),
        .i_full  (q_full),
        .o_ready (i_msg.ready),
        .o_push  (q_push),
        .o_cmd   (f_cmd)
    );

    dmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (f_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    dmp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_cmd   (q_cmd),
        .i_ready (o_res.ready),
        .o_pop   (q_pop),
        .o_valid (o_res.valid),
        .o_res   (b_res),
        .o_last  (o_res.last)
    );

    assign o_res.event_res      = b_res.ev;
    assign o_res.section        = b_res.sec;
    assign o_res.record_index   = b_res.idx;
    assign o_res.name_char      = b_res.ch;
    assign o_res.is_pointer     = b_res.isp;
    assign o_res.pointer_offset = b_res.off;
    assign o_res.rec_type       = b_res.rtype;
    assign o_res.rec_class      = b_res.rclass;
    assign o_res.rec_ttl        = b_res.ttl;
    assign o_res.msg_id         = b_res.id;
    assign o_res.hdr_flags      = b_res.flags;

endmodule

// File: rtl/dmp_front.sv
module dmp_front
    import dmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_start,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase           r_phase, n_phase;
    logic [3:0]       r_fbc, n_fbc;
    logic [1:0]       r_sec, n_sec;
    logic [15:0]      r_rl, n_rl;
    logic [15:0]      r_rec, n_rec;
    logic [2:0][15:0] r_cnt, n_cnt;
    logic [5:0]       r_lab, n_lab;
    logic             r_first, n_first;
    logic [15:0]      r_rd, n_rd;
    logic [15:0]      r_id, n_id;
    logic [15:0]      r_flags, n_flags;
    logic [15:0]      r_type, n_type;
    logic [15:0]      r_class, n_class;
    logic [31:0]      r_ttl, n_ttl;
    logic [5:0]       r_ph, n_ph;

    t_phase           eff_phase;
    logic [3:0]       eff_fbc;
    logic             accept;
    logic [15:0]      f_type, f_class, f_rd;
    logic [31:0]      f_ttl;
    logic [3:0]       f_n;
    logic             fix_done, fix_to_rdata;
    logic [15:0]      rd_dec, rl_dec;
    logic             rec_done;
    logic [2:0]       rec_pick;
    logic [15:0]      h_rl, h_id, h_flags;
    logic [2:0][15:0] h_cnt;
    logic [2:0]       h_pick;
    logic             cmd_valid;

    assign o_ready   = !i_full;
    assign accept    = i_valid && o_ready;
    assign eff_phase = i_start ? PH_HDR : r_phase;
    assign eff_fbc   = i_start ? 4'd0 : r_fbc;

    // field decode shared by next-state and command logic
    always_comb begin
        f_type  = (eff_fbc == 4'd0) ? 16'd0 : r_type;
        f_class = (eff_fbc == 4'd0) ? 16'd0 : r_class;
        f_ttl   = (eff_fbc == 4'd0) ? 32'd0 : r_ttl;
        f_rd    = (eff_fbc == 4'd0) ? 16'd0 : r_rd;
        case (eff_fbc)
            4'd0:    f_type  = {i_byte, 8'h00};
            4'd1:    f_type  = {f_type[15:8], i_byte};
            4'd2:    f_class = {i_byte, 8'h00};
            4'd3:    f_class = {f_class[15:8], i_byte};
            4'd4, 4'd5, 4'd6, 4'd7: f_ttl = {f_ttl[23:0], i_byte};
            4'd8:    f_rd    = {i_byte, 8'h00};
            default: f_rd    = {f_rd[15:8], i_byte};
        endcase
        f_n          = eff_fbc + 4'd1;
        fix_done     = (eff_phase == PH_FIXED) &&
                       (((r_sec == 2'd0) && (f_n == 4'd4)) ||
                        ((r_sec != 2'd0) && (f_n == 4'd10) && (f_rd == 16'd0)));
        fix_to_rdata = (eff_phase == PH_FIXED) && (r_sec != 2'd0) && (f_n == 4'd10) &&
                       (f_rd != 16'd0);
        rd_dec       = r_rd - 16'd1;
        rl_dec       = r_rl - 16'd1;
        rec_done     = fix_done || ((eff_phase == PH_RDATA) && (rd_dec == 16'd0));
        rec_pick     = pick_section({1'b0, r_sec} + 3'd1, r_cnt);

        h_rl    = r_rl;
        h_id    = r_id;
        h_flags = r_flags;
        h_cnt   = r_cnt;
        case (eff_fbc)
            4'd0:  h_id[15:8]    = i_byte;
            4'd1:  h_id[7:0]     = i_byte;
            4'd2:  h_flags[15:8] = i_byte;
            4'd3:  h_flags[7:0]  = i_byte;
            4'd4:  h_rl          = {i_byte, 8'h00};
            4'd5:  h_rl[7:0]     = i_byte;
            4'd6:  h_cnt[0]      = {i_byte, 8'h00};
            4'd7:  h_cnt[0][7:0] = i_byte;
            4'd8:  h_cnt[1]      = {i_byte, 8'h00};
            4'd9:  h_cnt[1][7:0] = i_byte;
            4'd10: h_cnt[2]      = {i_byte, 8'h00};
            4'd11: h_cnt[2][7:0] = i_byte;
            default: ;
        endcase
        h_pick = pick_section(3'd1, h_cnt);
    end

    // next state
    always_comb begin
        n_phase = eff_phase;
        n_fbc   = eff_fbc;
        n_sec   = r_sec;
        n_rl    = r_rl;
        n_rec   = r_rec;
        n_cnt   = r_cnt;
        n_lab   = r_lab;
        n_first = i_start ? 1'b1 : r_first;
        n_rd    = r_rd;
        n_id    = r_id;
        n_flags = r_flags;
        n_type  = r_type;
        n_class = r_class;
        n_ttl   = r_ttl;
        n_ph    = r_ph;
        case (eff_phase)
            PH_HDR: begin
                n_id    = h_id;
                n_flags = h_flags;
                n_rl    = h_rl;
                n_cnt   = h_cnt;
                n_fbc   = eff_fbc + 4'd1;
                if (eff_fbc == HDR_LAST) begin
                    n_rec   = 16'd0;
                    n_fbc   = 4'd0;
                    n_first = 1'b1;
                    n_phase = PH_NLEN;
                    if (h_rl != 16'd0) begin
                        n_sec = 2'd0;
                    end else if (h_pick[2]) begin
                        n_sec = h_pick[1:0];
                        n_rl  = h_cnt[h_pick[1:0] - 2'd1];
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
            end
            PH_NLEN: begin
                if (i_byte == 8'd0) begin
                    n_phase = PH_FIXED;
                    n_fbc   = 4'd0;
                end else if (i_byte <= MAX_LABEL) begin
                    n_first = 1'b0;
                    n_lab   = i_byte[5:0];
                    n_phase = PH_LABEL;
                end else if ((i_byte & PTR_MARK) == PTR_MARK) begin
                    n_ph    = i_byte[5:0];
                    n_phase = PH_PTR2;
                end else begin
                    n_phase = PH_ERR;
                end
            end
            PH_LABEL: begin
                n_lab = r_lab - 6'd1;
                if (n_lab == 6'd0) begin
                    n_phase = PH_NLEN;
                end
            end
            PH_PTR2: begin
                n_phase = PH_FIXED;
                n_fbc   = 4'd0;
            end
            PH_FIXED: begin
                n_type  = f_type;
                n_class = f_class;
                n_ttl   = f_ttl;
                n_rd    = f_rd;
                n_fbc   = f_n;
                if (fix_to_rdata) begin
                    n_phase = PH_RDATA;
                end
            end
            PH_RDATA: n_rd = rd_dec;
            default: ;
        endcase
        if (rec_done) begin
            n_rl    = rl_dec;
            n_rec   = r_rec + 16'd1;
            n_fbc   = 4'd0;
            n_first = 1'b1;
            n_phase = PH_NLEN;
            if (rl_dec == 16'd0) begin
                if (rec_pick[2]) begin
                    n_sec = rec_pick[1:0];
                    n_rl  = r_cnt[rec_pick[1:0] - 2'd1];
                    n_rec = 16'd0;
                end else begin
                    n_phase = PH_DONE;
                end
            end
        end
    end

    // command to the back end
    always_comb begin
        o_cmd         = '0;
        o_cmd.res.sec = r_sec;
        o_cmd.res.idx = r_rec;
        cmd_valid     = 1'b0;
        case (eff_phase)
            PH_HDR: begin
                if (eff_fbc == HDR_LAST) begin
                    cmd_valid       = 1'b1;
                    o_cmd.is_hdr    = 1'b1;
                    o_cmd.add_done  = (h_rl == 16'd0) && !h_pick[2];
                    o_cmd.cnt       = {h_cnt[2], h_cnt[1], h_cnt[0], h_rl};
                    o_cmd.res       = '0;
                    o_cmd.res.id    = h_id;
                    o_cmd.res.flags = h_flags;
                end
            end
            PH_NLEN: begin
                if (i_byte == 8'd0) begin
                    cmd_valid    = 1'b1;
                    o_cmd.res.ev = EV_NAME;
                end else if (i_byte <= MAX_LABEL) begin
                    cmd_valid    = !r_first && !i_start;
                    o_cmd.res.ev = EV_CHAR;
                    o_cmd.res.ch = DOT_CHAR;
                end else if ((i_byte & PTR_MARK) != PTR_MARK) begin
                    cmd_valid    = 1'b1;
                    o_cmd.res.ev = EV_BAD;
                end
            end
            PH_LABEL: begin
                cmd_valid    = 1'b1;
                o_cmd.res.ev = EV_CHAR;
                o_cmd.res.ch = i_byte;
            end
            PH_PTR2: begin
                cmd_valid     = 1'b1;
                o_cmd.res.ev  = EV_NAME;
                o_cmd.res.isp = 1'b1;
                o_cmd.res.off = {r_ph, i_byte};
            end
            default: ;
        endcase
        if (rec_done) begin
            cmd_valid        = 1'b1;
            o_cmd.res.ev     = EV_RECORD;
            o_cmd.res.rtype  = fix_done ? f_type : r_type;
            o_cmd.res.rclass = fix_done ? f_class : r_class;
            o_cmd.res.ttl    = fix_done ? f_ttl : r_ttl;
            o_cmd.add_done   = (rl_dec == 16'd0) && !rec_pick[2];
        end
    end

    assign o_push = accept && cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_fbc   <= 4'd0;
            r_sec   <= 2'd0;
            r_rl    <= 16'd0;
            r_rec   <= 16'd0;
            r_cnt   <= '0;
            r_lab   <= 6'd0;
            r_first <= 1'b1;
            r_rd    <= 16'd0;
            r_id    <= 16'd0;
            r_flags <= 16'd0;
            r_type  <= 16'd0;
            r_class <= 16'd0;
            r_ttl   <= 32'd0;
            r_ph    <= 6'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_fbc   <= n_fbc;
            r_sec   <= n_sec;
            r_rl    <= n_rl;
            r_rec   <= n_rec;
            r_cnt   <= n_cnt;
            r_lab   <= n_lab;
            r_first <= n_first;
            r_rd    <= n_rd;
            r_id    <= n_id;
            r_flags <= n_flags;
            r_type  <= n_type;
            r_class <= n_class;
            r_ttl   <= n_ttl;
            r_ph    <= n_ph;
        end
    end

endmodule

// File: rtl/dmp_queue.sv
module dmp_queue
    import dmp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wp, r_rp;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_count <= r_count + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

endmodule

// File: rtl/dmp_back.sv
module dmp_back
    import dmp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_cmd i_cmd,
    input  logic i_ready,
    output logic o_pop,
    output logic o_valid,
    output t_res o_res,
    output logic o_last
);

    logic [2:0] r_sub, n_sub;
    logic       r_ov;
    t_res       r_res, n_res;
    logic       r_last;
    logic       load, final_sub;
    logic [2:0] final_idx;
    logic [1:0] csec;

    assign load      = i_valid && (!r_ov || i_ready);
    assign final_idx = i_cmd.is_hdr ? (i_cmd.add_done ? 3'd5 : 3'd4)
                                    : (i_cmd.add_done ? 3'd1 : 3'd0);
    assign final_sub = (r_sub == final_idx);
    assign o_pop     = load && final_sub;
    assign n_sub     = final_sub ? 3'd0 : r_sub + 3'd1;
    assign csec      = 2'(r_sub - 3'd1);

    // expand one command into its result transactions
    always_comb begin
        n_res = '0;
        if (i_cmd.is_hdr) begin
            case (r_sub)
                3'd0: begin
                    n_res.ev    = EV_HDR;
                    n_res.id    = i_cmd.res.id;
                    n_res.flags = i_cmd.res.flags;
                end
                3'd1, 3'd2, 3'd3, 3'd4: begin
                    n_res.ev  = EV_COUNT;
                    n_res.sec = csec;
                    n_res.idx = i_cmd.cnt[csec];
                end
                default: n_res.ev = EV_MSG;
            endcase
        end else if (r_sub == 3'd0) begin
            n_res = i_cmd.res;
        end else begin
            n_res.ev = EV_MSG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_sub <= 3'd0;
        end else begin
            if (load) begin
                r_ov  <= 1'b1;
                r_sub <= n_sub;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= n_res;
            r_last <= final_sub;
        end
    end

    assign o_valid = r_ov;
    assign o_res   = r_res;
    assign o_last  = r_last;

endmodule

// File: rtl/dmp_checker.sv
module dmp_checker
    import dmp_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_event,
    input logic [1:0]  i_section,
    input logic [15:0] i_index,
    input logic        i_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_event) && $stable(i_index))
        else $error("stalled result changed");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_event == EV_MSG) |-> i_last)
        else $error("message done not last");

    a_hdr_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && (i_event == EV_HDR) |=>
        i_valid && (i_event == EV_COUNT) && (i_section == 2'd0))
        else $error("header not followed by question count");

    a_hdr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_event == EV_HDR) |-> !i_last)
        else $error("header result marked last");

endmodule

bind dns_message_parser_unit dmp_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_res.valid),
    .i_ready   (o_res.ready),
    .i_event   (o_res.event_res),
    .i_section (o_res.section),
    .i_index   (o_res.record_index),
    .i_last    (o_res.last)
);
